>>> hdl/bfc_pkg.sv
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types, constants and helpers for the box frustum classifier.
// ----------------------------------------------------------------------------
package bfc_pkg;

  // Visibility codes on the result channel
  typedef enum logic [1:0] {
    VIS_INSIDE  = 2'd0,
    VIS_CROSS   = 2'd1,
    VIS_OUTSIDE = 2'd2
  } vis_t;

  // Eight 64-bit matrix pair registers
  localparam int NUM_PAIRS = 8;
  localparam int PAIR_W    = 64;
  localparam int ADDR_W    = 6;
  typedef logic [NUM_PAIRS-1:0][PAIR_W-1:0] mat_pairs_t;

  // Datapath widths: corner coords, products, axis terms, pair sums, final sum
  localparam int CW = 34;
  localparam int PW = 66;
  localparam int TW = 67;
  localparam int KW = 41;
  localparam int QW = 68;
  localparam int SW = 69;

  // Q24.8 constants
  localparam logic signed [CW-1:0] TILE_SPAN_Q = 34'sd524288;
  localparam logic signed [CW-1:0] Z_BELOW_Q   = 34'sd65536;
  localparam logic signed [CW-1:0] Z_ABOVE_Q   = 34'sd76800;
  localparam logic [31:0]          NO_HEIGHT   = 32'h8000_0000;

  // Matrix entry at row r and used column k (k = 0: x, 1: y, 2: w)
  function automatic logic signed [31:0] mat_entry(mat_pairs_t m, int r, int k);
    logic [PAIR_W-1:0] pr;
    pr = m[3'(r * 2 + ((k == 2) ? 1 : 0))];
    return (k == 0) ? $signed(pr[31:0]) : $signed(pr[63:32]);
  endfunction

endpackage

>>> hdl/bfc_if.sv
// ----------------------------------------------------------------------------
// bfc_if
// Valid/ready channels for tile beats and result beats.
// ----------------------------------------------------------------------------
interface bfc_tile_if;
  logic        valid;
  logic        ready;
  logic [31:0] tile_origin_x;
  logic [31:0] tile_origin_y;
  logic [31:0] low_height;
  logic [31:0] high_height;
  logic [31:0] camera_x;
  logic [31:0] camera_y;
  logic [31:0] camera_z;
  logic [30:0] side_padding;

  modport source (output valid, tile_origin_x, tile_origin_y, low_height, high_height,
                  camera_x, camera_y, camera_z, side_padding, input ready);
  modport sink   (input valid, tile_origin_x, tile_origin_y, low_height, high_height,
                  camera_x, camera_y, camera_z, side_padding, output ready);
endinterface

interface bfc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] visibility;
  logic       land_present;

  modport source (output valid, visibility, land_present, input ready);
  modport sink   (input valid, visibility, land_present, output ready);
endinterface

>>> hdl/bfc_regs.sv
// ----------------------------------------------------------------------------
// bfc_regs
// APB register file holding the eight 64-bit matrix pair registers.
// ----------------------------------------------------------------------------
module bfc_regs
  import bfc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [PAIR_W-1:0]   pwdata,
  output logic [PAIR_W-1:0]   prdata,
  output logic                pready,
  output mat_pairs_t          mat
);

  logic [2:0] idx;
  assign idx    = paddr[5:3];
  assign pready = 1'b1;
  assign prdata = mat[idx];

  // Write on access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      mat <= '0;
    end else if (psel && penable && pwrite) begin
      mat[idx] <= pwdata;
    end
  end

endmodule

>>> hdl/box_frustum_classifier.sv
// ----------------------------------------------------------------------------
// box_frustum_classifier
// Five-stage pipeline from tile beat to result beat.
// Throughput one tile per cycle; each stage holds only while its successor is
// full and stalled, so bubbles are absorbed.
// Synchronous active-high reset clears all stage valids and matrix registers.
// ----------------------------------------------------------------------------
module box_frustum_classifier
  import bfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [PAIR_W-1:0] pwdata,
  output logic [PAIR_W-1:0] prdata,
  output logic              pready,
  bfc_tile_if.sink          tile,
  bfc_result_if.source      result
);

  mat_pairs_t mat;

  bfc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .mat
  );

  // Stage valids and enables
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;
  assign en5 = !v5 || result.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign tile.ready = en1;

  logic land1, land2, land3, land4;

  // Stage 1: corner coordinates relative to camera
  logic signed [CW-1:0] c_next [3][2];
  logic signed [CW-1:0] crd    [3][2];
  logic                 land_next;

  always_comb begin
    logic signed [CW-1:0] pad;
    pad = $signed({3'b0, tile.side_padding});
    c_next[0][0] = CW'($signed(tile.tile_origin_x)) - pad - CW'($signed(tile.camera_x));
    c_next[0][1] = CW'($signed(tile.tile_origin_x)) + TILE_SPAN_Q + pad
                   - CW'($signed(tile.camera_x));
    c_next[1][0] = CW'($signed(tile.tile_origin_y)) - pad - CW'($signed(tile.camera_y));
    c_next[1][1] = CW'($signed(tile.tile_origin_y)) + TILE_SPAN_Q + pad
                   - CW'($signed(tile.camera_y));
    c_next[2][0] = CW'($signed(tile.low_height)) - Z_BELOW_Q - CW'($signed(tile.camera_z));
    c_next[2][1] = CW'($signed(tile.high_height)) + Z_ABOVE_Q - CW'($signed(tile.camera_z));
    land_next = (tile.high_height != NO_HEIGHT)
             && ($signed(tile.low_height) <= $signed(tile.high_height));
  end

  // Stage 2: per-axis products, one per axis side and used column
  logic signed [PW-1:0] p_next [3][2][3];
  logic signed [PW-1:0] prod   [3][2][3];

  always_comb begin
    for (int ax = 0; ax < 3; ax++)
      for (int s = 0; s < 2; s++)
        for (int k = 0; k < 3; k++)
          p_next[ax][s][k] = PW'(crd[ax][s]) * PW'(mat_entry(mat, ax, k));
  end

  // Stage 3: plane terms per axis side (x+w, x-w, y+w, y-w)
  logic signed [TW-1:0] t_next [3][2][4];
  logic signed [TW-1:0] term   [3][2][4];
  logic signed [KW-1:0] k_next [4];
  logic signed [KW-1:0] kterm  [4];

  always_comb begin
    logic signed [KW-1:0] wx, wy, ww;
    for (int ax = 0; ax < 3; ax++)
      for (int s = 0; s < 2; s++) begin
        t_next[ax][s][0] = TW'(prod[ax][s][0]) + TW'(prod[ax][s][2]);
        t_next[ax][s][1] = TW'(prod[ax][s][0]) - TW'(prod[ax][s][2]);
        t_next[ax][s][2] = TW'(prod[ax][s][1]) + TW'(prod[ax][s][2]);
        t_next[ax][s][3] = TW'(prod[ax][s][1]) - TW'(prod[ax][s][2]);
      end
    // w row of the corner is 1.0, i.e. 256 in Q24.8
    wx = KW'(mat_entry(mat, 3, 0)) <<< 8;
    wy = KW'(mat_entry(mat, 3, 1)) <<< 8;
    ww = KW'(mat_entry(mat, 3, 2)) <<< 8;
    k_next[0] = wx + ww;
    k_next[1] = wx - ww;
    k_next[2] = wy + ww;
    k_next[3] = wy - ww;
  end

  // Stage 4: x+y pair sums and z+constant sums
  logic signed [QW-1:0] xy_next [2][2][4];
  logic signed [QW-1:0] xy      [2][2][4];
  logic signed [QW-1:0] zk_next [2][4];
  logic signed [QW-1:0] zk      [2][4];

  always_comb begin
    for (int t = 0; t < 4; t++) begin
      for (int a = 0; a < 2; a++)
        for (int b = 0; b < 2; b++)
          xy_next[a][b][t] = QW'(term[0][a][t]) + QW'(term[1][b][t]);
      for (int d = 0; d < 2; d++)
        zk_next[d][t] = QW'(term[2][d][t]) + QW'(kterm[t]);
    end
  end

  // Stage 5: corner sums, sign tests, reduction into the output register
  vis_t vis_next;

  always_comb begin
    logic signed [SW-1:0] sm;
    logic neg, pos;
    logic out_l, out_r, out_b, out_t, ins;
    out_l = 1'b1; out_r = 1'b1; out_b = 1'b1; out_t = 1'b1; ins = 1'b1;
    for (int a = 0; a < 2; a++)
      for (int b = 0; b < 2; b++)
        for (int d = 0; d < 2; d++)
          for (int t = 0; t < 4; t++) begin
            sm  = SW'(xy[a][b][t]) + SW'(zk[d][t]);
            neg = sm[SW-1];
            pos = !neg && (sm != '0);
            unique case (t)
              0: begin out_l &= neg; ins &= !neg; end
              1: begin out_r &= pos; ins &= !pos; end
              2: begin out_b &= neg; ins &= !neg; end
              default: begin out_t &= pos; ins &= !pos; end
            endcase
          end
    priority if (!land4)                            vis_next = VIS_CROSS;
    else if (out_l || out_r || out_b || out_t)      vis_next = VIS_OUTSIDE;
    else if (ins)                                   vis_next = VIS_INSIDE;
    else                                            vis_next = VIS_CROSS;
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else begin
      if (en1) v1 <= tile.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en1) begin crd <= c_next; land1 <= land_next; end
    if (en2) begin prod <= p_next; land2 <= land1; end
    if (en3) begin term <= t_next; kterm <= k_next; land3 <= land2; end
    if (en4) begin xy <= xy_next; zk <= zk_next; land4 <= land3; end
    if (en5) begin result.visibility <= vis_next; result.land_present <= land4; end
  end

  assign result.valid = v5;

endmodule

>>> hdl/bfc_checker.sv
// ----------------------------------------------------------------------------
// bfc_checker
// Port-level checks on the result channel of the classifier.
// ----------------------------------------------------------------------------
module bfc_props
  import bfc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic [1:0] visibility,
  input logic       land_present
);

  // Stalled beat holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(visibility) && $stable(land_present))
    else $error("result beat changed while stalled");

  // A tile without land is always reported as crossing
  a_noland: assert property (@(posedge clk) disable iff (rst)
    valid && !land_present |-> visibility == VIS_CROSS)
    else $error("no-land tile not reported as crossing");

  // Only defined visibility codes leave the block
  a_code: assert property (@(posedge clk) disable iff (rst)
    valid |-> visibility == VIS_INSIDE || visibility == VIS_CROSS
           || visibility == VIS_OUTSIDE)
    else $error("undefined visibility code");

  // Pipeline is empty right after reset
  a_rst: assert property (@(posedge clk) rst |=> !valid)
    else $error("result valid right after reset");

endmodule

bind box_frustum_classifier bfc_props u_bfc_props (
  .clk          (clk),
  .rst          (rst),
  .valid        (result.valid),
  .ready        (result.ready),
  .visibility   (result.visibility),
  .land_present (result.land_present)
);
